FILE: src/aeu_pkg.sv
// ----------------------------------------------------------------------------
// aeu_pkg
// Shared types and constants for the assembler expression alu.
// ----------------------------------------------------------------------------
package aeu_pkg;

    localparam int DATA_BITS_DEF = 16;
    localparam int CMD_BITS      = 5;
    localparam int BYTE_BITS     = 8;
    localparam int QUEUE_DEPTH   = 4;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_MUL   = 5'd0,
        CMD_ADD   = 5'd1,
        CMD_SUB   = 5'd2,
        CMD_UPLUS = 5'd3,
        CMD_DIV   = 5'd4,
        CMD_NEG   = 5'd5,
        CMD_EQ    = 5'd6,
        CMD_LT    = 5'd7,
        CMD_LE    = 5'd8,
        CMD_GT    = 5'd9,
        CMD_GE    = 5'd10,
        CMD_NE    = 5'd11,
        CMD_NOT   = 5'd12,
        CMD_AND   = 5'd13,
        CMD_OR    = 5'd14,
        CMD_XOR   = 5'd15,
        CMD_MOD   = 5'd16,
        CMD_SHL   = 5'd17,
        CMD_SHR   = 5'd18,
        CMD_HIGH  = 5'd19,
        CMD_LOW   = 5'd20
    } cmd_t;

    // how the back end finishes an item
    typedef enum logic [1:0] {
        KIND_ALU = 2'd0,
        KIND_DIV = 2'd1,
        KIND_MOD = 2'd2
    } kind_t;

    localparam int KIND_BITS = 2;

    // queue status seen by the front end
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

FILE: src/aeu_queue.sv
// ----------------------------------------------------------------------------
// aeu_queue
// Small fifo between the classifying front end and the execution back end.
// ----------------------------------------------------------------------------
module aeu_queue
    import aeu_pkg::*;
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head_data,
    output q_status_t        status
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [AW:0]      count_reg, count_next;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        logic [AW-1:0] r;
        r = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
        return r;
    endfunction

    assign status.full  = (count_reg == (AW+1)'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign head_data    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + (AW+1)'(push) - (AW+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        status.full |-> !push || pop) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        status.empty |-> !pop) else $error("queue underflow");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (AW+1)'(DEPTH)) else $error("queue count out of range");

endmodule

FILE: src/aeu_front.sv
// ----------------------------------------------------------------------------
// aeu_front
// Accepts items and tags each with the back end path it needs.
// ----------------------------------------------------------------------------
module aeu_front
    import aeu_pkg::*;
#(
    parameter int DATA_BITS = DATA_BITS_DEF
)
(
    input  logic                                       s_tvalid,
    output logic                                       s_tready,
    input  logic [CMD_BITS-1:0]                        cmd,
    input  logic [DATA_BITS-1:0]                       left_operand,
    input  logic [DATA_BITS-1:0]                       right_operand,
    input  q_status_t                                  status,
    output logic                                       push,
    output logic [KIND_BITS+CMD_BITS+2*DATA_BITS-1:0]  push_data
);

    kind_t kind;

    always_comb
    begin
        case (cmd)
            CMD_DIV: kind = KIND_DIV;
            CMD_MOD: kind = KIND_MOD;
            default: kind = KIND_ALU;
        endcase
    end

    assign s_tready  = !status.full;
    assign push      = s_tvalid && !status.full;
    assign push_data = {kind, cmd, right_operand, left_operand};

endmodule

FILE: src/aeu_back.sv
// ----------------------------------------------------------------------------
// aeu_back
// Executes items: alu and multiply in the first stage, then one quotient
// bit per stage, then an output register.
// ----------------------------------------------------------------------------
module aeu_back
    import aeu_pkg::*;
#(
    parameter int DATA_BITS = DATA_BITS_DEF
)
(
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic [KIND_BITS+CMD_BITS+2*DATA_BITS-1:0]  head_data,
    input  q_status_t                                  status,
    output logic                                       pop,
    output logic                                       m_tvalid,
    input  logic                                       m_tready,
    output logic [DATA_BITS-1:0]                       value,
    output logic                                       value_error
);

    localparam int DB = DATA_BITS;
    localparam int SW = $clog2(DB);
    localparam int NS = DB + 1;

    logic [DB-1:0]    a_in, b_in;
    logic [CMD_BITS-1:0] cmd_in;
    logic [KIND_BITS-1:0] kind_raw;
    kind_t            kind_in;
    logic [DB-1:0]    alu_res;
    logic [2*DB-1:0]  prod;
    logic [DB-1:0]    shl_res, shr_res;
    logic             en;

    logic             vld_reg  [NS];
    kind_t            kind_reg [NS];
    logic [DB-1:0]    res_reg  [NS];
    logic [DB-1:0]    b_reg    [NS];
    logic [DB-1:0]    rem_reg  [NS];
    logic [DB-1:0]    quo_reg  [NS];

    logic             out_vld_reg;
    logic [DB-1:0]    out_val_reg;
    logic             out_err_reg;
    logic [DB-1:0]    fin_val;
    logic             fin_err;

    assign {kind_raw, cmd_in, b_in, a_in} = head_data;
    assign kind_in = kind_t'(kind_raw);
    assign en  = !out_vld_reg || m_tready;
    assign pop = en && !status.empty;

    always_comb
    begin
        prod    = a_in * b_in;
        shl_res = a_in << b_in[SW-1:0];
        shr_res = a_in >> b_in[SW-1:0];
        if (b_in[BYTE_BITS-1:0] == '0)
        begin
            shl_res = a_in;
            shr_res = a_in;
        end
        else if (b_in >= DB'(DB))
        begin
            shl_res = '0;
            shr_res = '0;
        end
        case (cmd_in)
            CMD_MUL:  alu_res = prod[DB-1:0];
            CMD_ADD:  alu_res = a_in + b_in;
            CMD_SUB:  alu_res = a_in - b_in;
            CMD_NEG:  alu_res = '0 - a_in;
            CMD_EQ:   alu_res = {DB{a_in == b_in}};
            CMD_LT:   alu_res = {DB{a_in <  b_in}};
            CMD_LE:   alu_res = {DB{a_in <= b_in}};
            CMD_GT:   alu_res = {DB{a_in >  b_in}};
            CMD_GE:   alu_res = {DB{a_in >= b_in}};
            CMD_NE:   alu_res = {DB{a_in != b_in}};
            CMD_NOT:  alu_res = ~a_in;
            CMD_AND:  alu_res = a_in & b_in;
            CMD_OR:   alu_res = a_in | b_in;
            CMD_XOR:  alu_res = a_in ^ b_in;
            CMD_SHL:  alu_res = shl_res;
            CMD_SHR:  alu_res = shr_res;
            CMD_HIGH: alu_res = a_in >> BYTE_BITS;
            CMD_LOW:  alu_res = a_in & DB'(8'hff);
            default:  alu_res = a_in;
        endcase
    end

    always_comb
    begin
        fin_err = (kind_reg[NS-1] != KIND_ALU) && (b_reg[NS-1] == '0);
        case (kind_reg[NS-1])
            KIND_DIV: fin_val = fin_err ? '1 : quo_reg[NS-1];
            KIND_MOD: fin_val = fin_err ? '0 : rem_reg[NS-1];
            default:  fin_val = res_reg[NS-1];
        endcase
    end

    // restoring divide, one quotient bit per stage
    always_ff @(posedge clk)
    begin
        logic [DB:0] trial;
        if (en)
        begin
            kind_reg[0] <= kind_in;
            res_reg[0]  <= alu_res;
            b_reg[0]    <= b_in;
            rem_reg[0]  <= '0;
            quo_reg[0]  <= a_in;
            for (int i = 1; i < NS; i++)
            begin
                trial = {rem_reg[i-1], quo_reg[i-1][DB-1]};
                kind_reg[i] <= kind_reg[i-1];
                res_reg[i]  <= res_reg[i-1];
                b_reg[i]    <= b_reg[i-1];
                if (trial >= {1'b0, b_reg[i-1]})
                begin
                    rem_reg[i] <= DB'(trial - {1'b0, b_reg[i-1]});
                    quo_reg[i] <= {quo_reg[i-1][DB-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[i] <= trial[DB-1:0];
                    quo_reg[i] <= {quo_reg[i-1][DB-2:0], 1'b0};
                end
            end
            out_val_reg <= fin_val;
            out_err_reg <= fin_err;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NS; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= !status.empty;
            for (int i = 1; i < NS; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
            out_vld_reg <= vld_reg[NS-1];
        end
    end

    assign m_tvalid    = out_vld_reg;
    assign value       = out_val_reg;
    assign value_error = out_err_reg;

    a_err_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && out_err_reg |-> (out_val_reg == '1) || (out_val_reg == '0))
        else $error("error item with wrong value");
    a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg[NS-1]) && out_vld_reg)
        else $error("pipe moved while stalled");
    a_pop_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> en && !status.empty) else $error("pop without room");

endmodule

FILE: src/asm_expression_alu16.sv
// ----------------------------------------------------------------------------
// asm_expression_alu16
// One operator of a 16-bit assembler expression alu on stream channels.
// ----------------------------------------------------------------------------
// path: queue, alu stage, divide stages, then output register
// throughput: one item per cycle unless stalled; divide has DATA_BITS stages
// the queue of QUEUE_DEPTH items lets input keep flowing while output stalls
// reset: rst_n asynchronous active low clears queue and all valid bits
// ----------------------------------------------------------------------------
module asm_expression_alu16
    import aeu_pkg::*;
#(
    parameter int DATA_BITS = DATA_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    // cmd, left_operand, right_operand, zero fill
    input  logic [((CMD_BITS+2*DATA_BITS+7)/8)*8-1:0] s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // value, value_error, zero fill
    output logic [((DATA_BITS+1+7)/8)*8-1:0]          m_tdata
);

    localparam int QW = KIND_BITS + CMD_BITS + 2 * DATA_BITS;
    localparam int OW = ((DATA_BITS + 1 + 7) / 8) * 8;

    q_status_t          status;
    logic               push, pop;
    logic [QW-1:0]      push_data, head_data;
    logic [DATA_BITS-1:0] value;
    logic               value_error;

    aeu_front #(.DATA_BITS(DATA_BITS)) u_front (
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .cmd           (s_tdata[CMD_BITS-1:0]),
        .left_operand  (s_tdata[CMD_BITS+DATA_BITS-1:CMD_BITS]),
        .right_operand (s_tdata[CMD_BITS+2*DATA_BITS-1:CMD_BITS+DATA_BITS]),
        .status        (status),
        .push          (push),
        .push_data     (push_data)
    );

    aeu_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head_data (head_data),
        .status    (status)
    );

    aeu_back #(.DATA_BITS(DATA_BITS)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_data   (head_data),
        .status      (status),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .value       (value),
        .value_error (value_error)
    );

    assign m_tdata = OW'({value_error, value});

endmodule

FILE: tb/tb_asm_expression_alu16.sv
// ----------------------------------------------------------------------------
// tb_asm_expression_alu16
// Self-checking bench: directed table then random operator items, random
// idling on both sides, in-order compare with typed values or a predictor.
// ----------------------------------------------------------------------------
module tb_asm_expression_alu16
    import aeu_pkg::*;
();

    localparam int DW       = 16;
    localparam int S_BITS   = ((CMD_BITS+2*DW+7)/8)*8;
    localparam int M_BITS   = ((DW+1+7)/8)*8;
    localparam int N_RANDOM = 1500;
    localparam int WD_LIMIT = 2000;
    localparam int LATENCY  = DW + 3;

    typedef struct packed {
        logic          value_error;
        logic [DW-1:0] value;
    } alu_res_t;

    typedef struct {
        logic [CMD_BITS-1:0] cmd;
        logic [DW-1:0]       a;
        logic [DW-1:0]       b;
        logic                known;
        logic [DW-1:0]       value;
        logic                value_error;
    } row_t;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [S_BITS-1:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    logic [M_BITS-1:0] m_tdata;

    alu_res_t pending_results[$];
    int       failures;
    int       idle_cycles;
    bit       feeding_done;

    asm_expression_alu16 dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // cmd, left_operand, right_operand, zero fill
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)    // value, value_error, zero fill
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [DW-1:0] shift_result(logic [DW-1:0] a, logic [DW-1:0] b,
                                                    bit to_left);
        if (b[7:0] == 8'd0)
            return a;
        if (b >= DW)
            return '0;
        return to_left ? (a << b) : (a >> b);
    endfunction

    function automatic alu_res_t evaluate(logic [CMD_BITS-1:0] cmd, logic [DW-1:0] a,
                                          logic [DW-1:0] b);
        alu_res_t r;
        r.value = a;
        r.value_error = 1'b0;
        case (cmd)
            CMD_MUL:   r.value = a * b;
            CMD_ADD:   r.value = a + b;
            CMD_SUB:   r.value = a - b;
            CMD_UPLUS: r.value = a;
            CMD_DIV:
                if (b == 0) begin r.value = '1; r.value_error = 1'b1; end
                else r.value = a / b;
            CMD_NEG:   r.value = -a;
            CMD_EQ:    r.value = {DW{a == b}};
            CMD_LT:    r.value = {DW{a < b}};
            CMD_LE:    r.value = {DW{a <= b}};
            CMD_GT:    r.value = {DW{a > b}};
            CMD_GE:    r.value = {DW{a >= b}};
            CMD_NE:    r.value = {DW{a != b}};
            CMD_NOT:   r.value = ~a;
            CMD_AND:   r.value = a & b;
            CMD_OR:    r.value = a | b;
            CMD_XOR:   r.value = a ^ b;
            CMD_MOD:
                if (b == 0) begin r.value = '0; r.value_error = 1'b1; end
                else r.value = a % b;
            CMD_SHL:   r.value = shift_result(a, b, 1'b1);
            CMD_SHR:   r.value = shift_result(a, b, 1'b0);
            CMD_HIGH:  r.value = a >> 8;
            CMD_LOW:   r.value = a & 16'h00ff;
            default:   r.value = a;
        endcase
        return r;
    endfunction

    // valid stays high into the next item when no gap is drawn
    task automatic send_item(logic [CMD_BITS-1:0] cmd, logic [DW-1:0] a, logic [DW-1:0] b);
        int gap;
        gap = $urandom_range(0, 5);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_BITS'({b, a, cmd});
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic run_item(logic [CMD_BITS-1:0] cmd, logic [DW-1:0] a, logic [DW-1:0] b);
        pending_results.push_back(evaluate(cmd, a, b));
        send_item(cmd, a, b);
    endtask

    // result side: random stalls, in-order compare
    initial
    begin
        alu_res_t want;
        alu_res_t got;
        int stall;
        m_tready = 1'b0;
        stall = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                got = alu_res_t'(m_tdata[DW:0]);
                if (pending_results.size() == 0)
                begin
                    $error("unexpected result value=%h", got.value);
                    failures++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.value !== want.value)
                    begin
                        $error("value expected %h actual %h", want.value, got.value);
                        failures++;
                    end
                    if (got.value_error !== want.value_error)
                    begin
                        $error("value_error expected %b actual %b",
                               want.value_error, got.value_error);
                        failures++;
                    end
                end
                stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
            end
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                stall--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // watchdog on accept-free cycles
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else if (s_tvalid || pending_results.size() != 0 || !feeding_done)
                idle_cycles++;
            if (idle_cycles >= WD_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial
    begin
        row_t rows[$];
        row_t r;
        alu_res_t k;
        logic [CMD_BITS-1:0] cmd;
        logic [DW-1:0] a;
        logic [DW-1:0] b;
        int n;

        failures = 0;
        feeding_done = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;

        // directed table: expected typed in for obvious rows, else predictor
        rows.push_back('{CMD_DIV,   16'h1234, 16'h0000, 1'b1, 16'hffff, 1'b1});
        rows.push_back('{CMD_MOD,   16'h1234, 16'h0000, 1'b1, 16'h0000, 1'b1});
        rows.push_back('{CMD_ADD,   16'hffff, 16'h0001, 1'b1, 16'h0000, 1'b0});
        rows.push_back('{CMD_SUB,   16'h0000, 16'h0001, 1'b1, 16'hffff, 1'b0});
        rows.push_back('{CMD_MUL,   16'hffff, 16'hffff, 1'b1, 16'h0001, 1'b0});
        rows.push_back('{CMD_UPLUS, 16'habcd, 16'hffff, 1'b1, 16'habcd, 1'b0});
        rows.push_back('{CMD_NEG,   16'h0001, 16'h0000, 1'b1, 16'hffff, 1'b0});
        rows.push_back('{CMD_EQ,    16'hffff, 16'hffff, 1'b1, 16'hffff, 1'b0});
        rows.push_back('{CMD_LT,    16'h0000, 16'hffff, 1'b1, 16'hffff, 1'b0});
        rows.push_back('{CMD_LE,    16'hffff, 16'h0000, 1'b1, 16'h0000, 1'b0});
        rows.push_back('{CMD_GT,    16'h8000, 16'h7fff, 1'b0, 16'h0, 1'b0});
        rows.push_back('{CMD_GE,    16'h7fff, 16'h7fff, 1'b0, 16'h0, 1'b0});
        rows.push_back('{CMD_NE,    16'h0000, 16'h0000, 1'b1, 16'h0000, 1'b0});
        rows.push_back('{CMD_NOT,   16'h0000, 16'h5555, 1'b1, 16'hffff, 1'b0});
        rows.push_back('{CMD_AND,   16'hff00, 16'h0ff0, 1'b0, 16'h0, 1'b0});
        rows.push_back('{CMD_OR,    16'haaaa, 16'h5555, 1'b0, 16'h0, 1'b0});
        rows.push_back('{CMD_XOR,   16'hffff, 16'h5a5a, 1'b0, 16'h0, 1'b0});
        rows.push_back('{CMD_SHL,   16'h1234, 16'h0100, 1'b1, 16'h1234, 1'b0});
        rows.push_back('{CMD_SHR,   16'h8001, 16'h0010, 1'b1, 16'h0000, 1'b0});
        rows.push_back('{CMD_SHL,   16'h0001, 16'h000f, 1'b1, 16'h8000, 1'b0});
        rows.push_back('{CMD_SHR,   16'hffff, 16'h0101, 1'b1, 16'h0000, 1'b0});
        rows.push_back('{CMD_HIGH,  16'habcd, 16'h0000, 1'b1, 16'h00ab, 1'b0});
        rows.push_back('{CMD_LOW,   16'habcd, 16'h0000, 1'b1, 16'h00cd, 1'b0});
        rows.push_back('{5'd31,     16'hbeef, 16'hffff, 1'b1, 16'hbeef, 1'b0});
        rows.push_back('{5'd21,     16'h0000, 16'h1111, 1'b1, 16'h0000, 1'b0});

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            r = rows[i];
            if (r.known)
            begin
                k.value = r.value;
                k.value_error = r.value_error;
                pending_results.push_back(k);
                send_item(r.cmd, r.a, r.b);
            end
            else
                run_item(r.cmd, r.a, r.b);
        end
        s_tvalid <= 1'b0;

        // hold off until the block has drained
        wait (pending_results.size() == 0);
        @(posedge clk);

        for (n = 0; n < N_RANDOM; n++)
        begin
            cmd = ($urandom_range(0, 15) == 0) ? CMD_BITS'($urandom_range(21, 31))
                                               : CMD_BITS'($urandom_range(0, 20));
            a = DW'($urandom);
            b = DW'($urandom);
            case ($urandom_range(0, 7))
                0: b = 16'h0000;
                1: b = DW'($urandom_range(0, 20));
                2: b = {8'($urandom_range(0, 255)), 8'h00};
                3: b = a;
                4: a = DW'($urandom_range(0, 3)) == 0 ? 16'hffff : a;
                default: ;
            endcase
            if ((cmd == CMD_SHL || cmd == CMD_SHR) && $urandom_range(0, 1))
                b = DW'($urandom_range(0, 17));
            run_item(cmd, a, b);
        end
        s_tvalid <= 1'b0;
        feeding_done = 1'b1;

        wait (pending_results.size() == 0);
        repeat (LATENCY + 5) @(posedge clk);
        if (failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: files.f
src/aeu_pkg.sv
src/aeu_queue.sv
src/aeu_front.sv
src/aeu_back.sv
src/asm_expression_alu16.sv
tb/tb_asm_expression_alu16.sv
